FILE: src/pbrd_pkg.sv
// Package for the PackBits row decoder: field widths, codes and limits.
// Depends on nothing; every other file of the block imports it.
package pbrd_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 8;
  localparam int ROW_WIDTH_W = 15;

  // Default upper bound for the configured row width.
  localparam int DEF_MAX_ROW_WIDTH = 16384;

  // Row width after reset.
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 15'd16384;

  // Header byte that does nothing, and the base of the repeat length.
  localparam logic [BYTE_W-1:0] NOOP_HEADER = 8'd128;
  localparam logic [BYTE_W:0]   REPEAT_BASE = 9'd257;

  // Parse phase codes.
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LITERAL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_REPEAT  = 2'd2;

endpackage : pbrd_pkg

FILE: src/pbrd_in_if.sv
// Input channel of the PackBits row decoder: one compressed byte per item.
// Depends on pbrd_pkg for the field widths.
interface pbrd_in_if;
  import pbrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              row_end;

  modport source (output valid, output in_byte, output row_end, input ready);
  modport sink   (input valid, input in_byte, input row_end, output ready);

endinterface : pbrd_in_if

FILE: src/pbrd_out_if.sv
// Output channel of the PackBits row decoder: one decoded run or status per item.
// Depends on pbrd_pkg for the field widths.
interface pbrd_out_if;
  import pbrd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] out_count;
  logic               row_done;
  logic               row_ok;

  modport source (output valid, output out_byte, output out_count, output row_done,
                  output row_ok, input ready);
  modport sink   (input valid, input out_byte, input out_count, input row_done,
                  input row_ok, output ready);

endinterface : pbrd_out_if

FILE: src/packbits_row_decoder_unit.sv
// Top level of the PackBits row decoder: input register, parse logic, result register.
// Depends on pbrd_pkg, pbrd_in_if and pbrd_out_if.
//
// Usage. Compressed bytes of one image row enter on in_i, one byte per item,
// with row_end set on the last byte of the row. Each item yields at most one
// item on out_o: a literal byte with out_count 1, a whole repeat run with its
// clipped count, or, on the last byte of a row, the closing item with row_done
// set and row_ok telling whether exactly the configured width came out and no
// run was cut off. Header bytes and bytes past a full row yield nothing unless
// they end the row. The row width is written through cfg_we_i/cfg_wdata_i while
// the block is idle; 0 is stored as 1 and values above MAX_ROW_WIDTH are
// clipped to it.
// Timing. An accepted item is held in the input register until it advances; the
// parse logic then updates the row state and loads the result register, so a
// result is offered from the result register once its item advances. One item
// is taken every cycle unless the receiver stalls with results in both stages.
// Reset clears all control state, the parse phase and the byte count, and sets
// the row width to 16384. When the receiver stalls, the result register holds,
// and the input register still drains items that yield no result; in_i.ready
// drops only when a result waits in both the parse stage and the result register.
module packbits_row_decoder_unit #(
  parameter int MAX_ROW_WIDTH = pbrd_pkg::DEF_MAX_ROW_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pbrd_pkg::ROW_WIDTH_W-1:0] cfg_wdata_i,
  pbrd_in_if.sink                          in_i,
  pbrd_out_if.source                       out_o
);
  import pbrd_pkg::*;

  // Row width register with the clamp applied on write.
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [ROW_WIDTH_W-1:0] cfg_nonzero;

  assign cfg_nonzero = (cfg_wdata_i == '0) ? ROW_WIDTH_W'(1) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      if (32'(cfg_nonzero) > MAX_ROW_WIDTH) begin
        row_width_q <= ROW_WIDTH_W'(MAX_ROW_WIDTH);
      end else begin
        row_width_q <= cfg_nonzero;
      end
    end
  end

  // Input register.
  logic              s1_valid_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_end_q;
  logic              s1_advance;
  logic              s1_emit;

  // The result register can take a new result when empty or being drained.
  assign s1_advance = s1_valid_q && (!s1_emit || !out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_end_q  <= in_i.row_end;
    end
  end

  // Row parse state.
  logic [PHASE_W-1:0]     phase_q, phase_d, phase_step;
  logic [COUNT_W-1:0]     lit_left_q, lit_left_d, lit_left_step;
  logic [COUNT_W-1:0]     rep_len_q, rep_len_d, rep_len_step;
  logic [ROW_WIDTH_W-1:0] written_q, written_d, written_step;
  logic [ROW_WIDTH_W-1:0] room;
  logic [BYTE_W-1:0]      res_byte;
  logic [COUNT_W-1:0]     res_count;
  logic                   res_ok;

  assign room = (row_width_q > written_q) ? (row_width_q - written_q) : '0;

  always_comb begin
    phase_step    = phase_q;
    lit_left_step = lit_left_q;
    rep_len_step  = rep_len_q;
    written_step  = written_q;
    res_byte      = '0;
    res_count     = '0;
    unique case (phase_q)
      PH_LITERAL: begin
        if (room != '0) begin
          res_byte     = s1_byte_q;
          res_count    = COUNT_W'(1);
          written_step = written_q + ROW_WIDTH_W'(1);
        end
        lit_left_step = lit_left_q - COUNT_W'(1);
        if (lit_left_step == '0) begin
          phase_step = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        // The room left is clipped against a repeat length of at most 128.
        if (ROW_WIDTH_W'(rep_len_q) < room) begin
          res_count = rep_len_q;
        end else begin
          res_count = COUNT_W'(room);
        end
        res_byte     = (res_count != '0) ? s1_byte_q : '0;
        written_step = written_q + ROW_WIDTH_W'(res_count);
        rep_len_step = '0;
        phase_step   = PH_HEADER;
      end
      default: begin
        // Header position; the unused phase code behaves the same way.
        phase_step = PH_HEADER;
        if (written_q < row_width_q) begin
          if (s1_byte_q < NOOP_HEADER) begin
            lit_left_step = s1_byte_q + COUNT_W'(1);
            phase_step    = PH_LITERAL;
          end else if (s1_byte_q > NOOP_HEADER) begin
            rep_len_step = COUNT_W'(REPEAT_BASE - {1'b0, s1_byte_q});
            phase_step   = PH_REPEAT;
          end
        end
      end
    endcase
  end

  assign s1_emit = s1_end_q || (res_count != '0);
  assign res_ok  = s1_end_q && (phase_step == PH_HEADER) && (written_step == row_width_q);

  // The end of a row returns the parse state to its reset values.
  always_comb begin
    if (s1_end_q) begin
      phase_d    = PH_HEADER;
      lit_left_d = '0;
      rep_len_d  = '0;
      written_d  = '0;
    end else begin
      phase_d    = phase_step;
      lit_left_d = lit_left_step;
      rep_len_d  = rep_len_step;
      written_d  = written_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      lit_left_q <= '0;
      rep_len_q  <= '0;
      written_q  <= '0;
    end else if (s1_advance) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      rep_len_q  <= rep_len_d;
      written_q  <= written_d;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_emit) begin
      out_o.out_byte  <= res_byte;
      out_o.out_count <= res_count;
      out_o.row_done  <= s1_end_q;
      out_o.row_ok    <= res_ok;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule : packbits_row_decoder_unit

FILE: src/pbrd_checker.sv
// Port-level checker for the PackBits row decoder, bound to the top level.
// Depends on pbrd_pkg and on the port names of packbits_row_decoder_unit.
module pbrd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [pbrd_pkg::BYTE_W-1:0]  out_byte_i,
  input logic [pbrd_pkg::COUNT_W-1:0] out_count_i,
  input logic                         row_done_i,
  input logic                         row_ok_i
);
  import pbrd_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pbrd: result dropped while stalled");

  // A success status only comes with the closing result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && row_ok_i |-> row_done_i)
    else $error("pbrd: row_ok without row_done");

  // A result without bytes is only sent to close a row, and carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_count_i == '0) |-> row_done_i && (out_byte_i == '0))
    else $error("pbrd: empty result that does not close a row");

  // No run is longer than the longest PackBits repeat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= NOOP_HEADER)
    else $error("pbrd: run count above 128");

endmodule : pbrd_checker

bind packbits_row_decoder_unit pbrd_checker u_pbrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_count_i (out_o.out_count),
  .row_done_i  (out_o.row_done),
  .row_ok_i    (out_o.row_ok)
);

FILE: tb/pbrd_decode_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the row width port of the PackBits row decoder.
// It decodes every accepted item itself and checks each result against it.
// Depends on pbrd_pkg, pbrd_in_if and pbrd_out_if.
module pbrd_decode_checker
  import pbrd_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ROW_WIDTH_W-1:0] cfg_wdata_i,
  pbrd_in_if                     in_i,
  pbrd_out_if                    out_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               done;
    logic               ok;
  } run_t;

  localparam int REPORT_CAP = 40;

  run_t expected_runs[$];

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [PHASE_W-1:0]     phase;
  logic [7:0]             literal_left;
  logic [7:0]             repeat_len;
  logic [ROW_WIDTH_W-1:0] written;
  int                     reports;

  // Works out the result, if any, that one compressed byte causes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [ROW_WIDTH_W-1:0] room;
    run_t                   r;
    r = '0;
    room = (row_width > written) ? row_width - written : '0;
    case (phase)
      PH_LITERAL: begin
        if (room != 0) begin
          r.value = b;
          r.count = 8'd1;
          written = written + 1'b1;
        end
        literal_left = literal_left - 1'b1;
        if (literal_left == 0) phase = PH_HEADER;
      end
      PH_REPEAT: begin
        r.count = ({7'd0, repeat_len} < room) ? repeat_len : room[COUNT_W-1:0];
        r.value = (r.count != 0) ? b : '0;
        written = written + {7'd0, r.count};
        repeat_len = '0;
        phase = PH_HEADER;
      end
      default: begin
        // Header position; an unused phase code is treated the same way.
        phase = PH_HEADER;
        if (written < row_width) begin
          if (b < NOOP_HEADER) begin
            literal_left = b + 8'd1;
            phase = PH_LITERAL;
          end else if (b > NOOP_HEADER) begin
            repeat_len = 8'(REPEAT_BASE - {1'b0, b});
            phase = PH_REPEAT;
          end
        end
      end
    endcase
    if (last || r.count != 0) begin
      if (last) begin
        r.done = 1'b1;
        r.ok = (phase == PH_HEADER) && (written == row_width);
        phase = PH_HEADER;
        literal_left = '0;
        repeat_len = '0;
        written = '0;
      end
      expected_runs.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      fail_count_o++;
      if (reports < REPORT_CAP)
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      reports++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_t exp_run;
    if (!rst_ni) begin
      row_width    = ROW_WIDTH_RESET;
      phase        = PH_HEADER;
      literal_left = '0;
      repeat_len   = '0;
      written      = '0;
      expected_runs.delete();
      fail_count_o = 0;
      pending_o    = 0;
      reports      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == 0) row_width = ROW_WIDTH_W'(1);
        else if (cfg_wdata_i > MAX_ROW_WIDTH) row_width = MAX_ROW_WIDTH[ROW_WIDTH_W-1:0];
        else row_width = cfg_wdata_i;
      end
      if (in_i.valid && in_i.ready) decode_byte(in_i.in_byte, in_i.row_end);
      if (out_i.valid && out_i.ready) begin
        if (expected_runs.size() == 0) begin
          fail_count_o++;
          if (reports < REPORT_CAP)
            $display("%0t: unexpected result: expected none, got byte %0d count %0d done %0b ok %0b",
                     $time, out_i.out_byte, out_i.out_count, out_i.row_done, out_i.row_ok);
          reports++;
        end else begin
          exp_run = expected_runs.pop_front();
          check_field("out_byte", exp_run.value, out_i.out_byte);
          check_field("out_count", exp_run.count, out_i.out_count);
          check_field("row_done", exp_run.done, out_i.row_done);
          check_field("row_ok", exp_run.ok, out_i.row_ok);
        end
      end
      pending_o = expected_runs.size();
    end
  end

endmodule : pbrd_decode_checker

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the PackBits row decoder testbench: clock, reset, stimulus and verdict.
// Depends on pbrd_pkg, both channel interfaces, the decoder and pbrd_decode_checker.
module tb_top;
  import pbrd_pkg::*;

  // Kinds of compressed rows that the random part builds.
  typedef enum int {
    ROW_EXACT,
    ROW_OVERFILL,
    ROW_SHORT,
    ROW_CUT,
    ROW_NOISE,
    ROW_LONG_RUNS
  } row_kind_e;

  // The run stops once this many items have gone in; the last stretch has no idling.
  localparam int RUN_ITEMS   = 600;
  localparam int CALM_FROM   = 540;
  // One row at the largest width, made of maximum repeats, goes in at this point.
  localparam int FULL_ROW_AT = 320;
  // The receiver holds off once for a long stretch so that the block fills up.
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TIMEOUT_NS  = 2_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [ROW_WIDTH_W-1:0] cfg_wdata;
  int                     fail_count;
  int                     pending;

  int                     sent_items;
  bit                     calm;
  bit                     held;
  logic [BYTE_W-1:0]      row_bytes[$];

  pbrd_in_if  in_if ();
  pbrd_out_if out_if ();

  packbits_row_decoder_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  pbrd_decode_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one item and returns at the edge that accepts it. Every call starts
  // at a rising edge, so the next item's values land in the same time step as
  // the acceptance and valid stays high between back-to-back items.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.row_end <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_items++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected result has come out. A
  // header byte yields no result, so the extra cycles let such an item leave
  // the two-stage pipe before anything that depends on the row state changes.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A new width must be written only while the block is idle; the block itself does not enforce this.
  task automatic write_row_width(input logic [ROW_WIDTH_W-1:0] value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds one compressed row into row_bytes. Exact rows decode to the width,
  // short rows stop before it, overfilled rows go past it, cut rows lose one to three
  // bytes of their tail, and noise rows are random bytes.
  task automatic build_row(input int width, input row_kind_e kind);
    int goal;
    int made;
    int room;
    int n;
    row_bytes.delete();
    made = 0;
    if (kind == ROW_NOISE) begin
      repeat ($urandom_range(1, 12)) row_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      case (kind)
        ROW_SHORT:    goal = $urandom_range(0, width - 1);
        ROW_OVERFILL: goal = width + $urandom_range(1, 8);
        default:      goal = width;
      endcase
      while (made < goal) begin
        room = (goal - made > 128) ? 128 : goal - made;
        if (kind != ROW_LONG_RUNS && $urandom_range(0, 11) == 0)
          row_bytes.push_back(NOOP_HEADER);
        n = (kind == ROW_LONG_RUNS) ? room : $urandom_range(1, room);
        if (n >= 2 && (kind == ROW_LONG_RUNS || $urandom_range(0, 1) == 1)) begin
          row_bytes.push_back(8'(257 - n));
          row_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          row_bytes.push_back(8'(n - 1));
          repeat (n) row_bytes.push_back(8'($urandom_range(0, 255)));
        end
        made += n;
      end
      if (kind == ROW_CUT)
        repeat ($urandom_range(1, (row_bytes.size() < 3) ? row_bytes.size() : 3))
          void'(row_bytes.pop_back());
    end
    // A row needs at least one byte to carry the row end flag.
    if (row_bytes.size() == 0) row_bytes.push_back(NOOP_HEADER);
  endtask

  task automatic send_row();
    foreach (row_bytes[i]) send_item(row_bytes[i], i == row_bytes.size() - 1);
  endtask

  // Receiver side: random stall bursts, one long hold-off, and no stalls at all
  // once the run has turned calm. Each pass drives ready once and then keeps it
  // for a stretch. The long hold-off starts while an item is on offer,
  // so the sender keeps pushing into the stalled block.
  initial begin
    int stretch;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent_items >= HOLD_AT && in_if.valid) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        stretch = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stretch = $urandom_range(1, 16);
      end else begin
        out_if.ready <= 1'b1;
        stretch = calm ? 1 : $urandom_range(1, 24);
      end
      repeat (stretch) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int        corner_widths[8];
    int        width;
    int        guard;
    bit        full_row_done;
    row_kind_e kind;
    corner_widths = '{0, 1, 2, 3, 127, 128, 129, 255};
    full_row_done = 1'b0;
    sent_items    = 0;
    calm          = 1'b0;
    held          = 1'b0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.row_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A no-op header that ends a row at the reset width leaves the row short.
    send_item(8'h80, 1'b1);

    // A width of 0 is stored as 1. The one-byte literal fills the row, so the
    // closing header byte is dropped and the row still comes out whole.
    write_row_width('0);
    send_item(8'h00, 1'b0);
    send_item(8'hAB, 1'b0);
    send_item(8'h80, 1'b1);

    // Width 3: a repeat of two, then a literal of two whose last byte no
    // longer fits and is consumed without output.
    write_row_width(15'd3);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b1);
    // The longest repeat is clipped to the room left, on the row's last byte.
    send_item(8'h81, 1'b0);
    send_item(8'h00, 1'b1);
    // Rows that end on a literal header, on a repeat header, and inside a
    // literal run are cut off and close with a bad status.
    send_item(8'h7F, 1'b1);
    send_item(8'h90, 1'b1);
    send_item(8'h02, 1'b0);
    send_item(8'hAA, 1'b1);
    // A no-op header ahead of a repeat of three.
    send_item(8'h80, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'hFF, 1'b1);

    // A write above the limit is clipped to it. The width then shrinks in the
    // middle of a row below what has already come out, so nothing fits any more.
    write_row_width(15'd16385);
    send_item(8'h81, 1'b0);
    send_item(8'h77, 1'b0);
    write_row_width(15'd5);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);

    // Random phases: a new width, then a few rows of mixed kinds.
    while (sent_items < RUN_ITEMS) begin
      if (!full_row_done && sent_items >= FULL_ROW_AT) begin
        // All-ones write, clipped to the largest width, filled by maximum repeats.
        // The decoder runs with its default width limit.
        full_row_done = 1'b1;
        write_row_width('1);
        build_row(DEF_MAX_ROW_WIDTH, ROW_LONG_RUNS);
        send_row();
        build_row(1, ROW_NOISE);
        send_row();
      end
      if ($urandom_range(0, 9) < 8) width = $urandom_range(1, 32);
      else width = corner_widths[$urandom_range(0, 7)];
      write_row_width(ROW_WIDTH_W'(width));
      if (width == 0) width = 1;
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 9))
          5:       kind = ROW_OVERFILL;
          6:       kind = ROW_SHORT;
          7:       kind = ROW_CUT;
          8:       kind = ROW_NOISE;
          default: kind = ROW_EXACT;
        endcase
        build_row(width, kind);
        send_row();
        if (sent_items >= CALM_FROM) calm = 1'b1;
      end
    end

    // Let the last results drain, then keep watching for stray ones before the verdict.
    in_if.valid <= 1'b0;
    @(posedge clk);
    for (guard = 0; guard < DRAIN_LIMIT && pending != 0; guard++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never came out", $time, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule : tb_top
